### src/tls_pkg.sv
// Shared types and constants for the text line splitter.
// Used by tls_core and text_line_splitter_top; depends on nothing else.
`default_nettype none

package tls_pkg;

    // Input command codes.
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Byte values the splitter looks for.
    localparam logic [7:0] BOM0  = 8'hEF;
    localparam logic [7:0] BOM1  = 8'hBB;
    localparam logic [7:0] BOM2  = 8'hBF;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // One request can produce at most this many results.
    localparam int MaxResults = 4;
    localparam int SlotW      = $clog2(MaxResults);
    localparam int CountW     = $clog2(MaxResults + 1);
    localparam int IndexW     = 32;

    // What one result carries.
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_LINE = 2'd1,
        KIND_END  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
    } slot_t;

    // All results caused by one input request. At most one of them
    // closes a line, so a single line index is shared by the group.
    typedef struct packed {
        logic [CountW-1:0]           count;
        slot_t [MaxResults-1:0]      slot;
        logic [IndexW-1:0]           index;
    } bundle_t;

endpackage

`default_nettype wire

### src/text_line_splitter_top.sv
// Top level of the text line splitter: stream handshakes and result buffer.
// Depends on tls_pkg and tls_core.
`default_nettype none

// Each accepted request is decoded in the cycle it is taken and its whole
// group of results (none to four) lands in one output buffer, from which
// the results leave one per cycle while m_tready is high, starting the next
// cycle. Plain text therefore runs at one byte per cycle when the receiver
// does not stall; a request that yields several results holds the buffer
// until all are taken, which only happens around a held byte order mark, a line
// end after a CR, or the end of stream. A new request is taken in the same
// cycle the final result of the previous group is taken.
module text_line_splitter_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] out_byte, [39:8] line_index
    output logic [2:0]       m_tuser,   // [0] byte_valid, [1] line_end, [2] stream_end
    output logic             m_tlast
);
    import tls_pkg::*;

    logic              s_take;
    logic              m_take;
    logic              group_done;
    bundle_t           bundle;
    bundle_t           bundle_reg, bundle_next;
    logic              valid_reg, valid_next;
    logic [SlotW-1:0]  pos_reg, pos_next;
    slot_t             cur;
    logic              is_last;

    tls_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (s_take),
        .cmd       (s_tuser[0]),
        .data_byte (s_tdata),
        .bundle    (bundle)
    );

    // The current result and whether it closes its group.
    assign cur        = bundle_reg.slot[pos_reg];
    assign is_last    = ({1'b0, pos_reg} + 1'b1) == bundle_reg.count;
    assign m_take     = valid_reg && m_tready;
    assign group_done = m_take && is_last;
    assign s_tready   = !valid_reg || group_done;
    assign s_take     = s_tvalid && s_tready;

    // Result buffer: loaded with a new group, or stepped one result ahead.
    always_comb begin
        bundle_next = bundle_reg;
        valid_next  = valid_reg;
        pos_next    = pos_reg;
        if (s_take) begin
            bundle_next = bundle;
            valid_next  = (bundle.count != '0);
            pos_next    = '0;
        end else if (group_done) begin
            valid_next = 1'b0;
        end else if (m_take) begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        bundle_reg <= bundle_next;
    end

    // Output fields of the current result.
    assign m_tvalid     = valid_reg;
    assign m_tlast      = is_last;
    assign m_tdata[7:0] = (cur.kind == KIND_BYTE) ? cur.value : 8'd0;
    assign m_tdata[39:8] = (cur.kind == KIND_LINE) ? bundle_reg.index : '0;
    assign m_tuser[0]   = (cur.kind == KIND_BYTE);
    assign m_tuser[1]   = (cur.kind == KIND_LINE);
    assign m_tuser[2]   = (cur.kind == KIND_END);

`ifndef SYNTH
    // A held group is never empty and the read position stays inside it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (bundle_reg.count != '0) && ({1'b0, pos_reg} < bundle_reg.count))
        else $error("result buffer position outside its group");

    // Every shown result is exactly one kind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tuser))
        else $error("result carries no kind or several kinds");

    // The stream end marker is always the final result of its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> m_tlast)
        else $error("stream end marker is not the final result");

    // A closed line always has a nonzero index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[39:8] != '0))
        else $error("line end with zero line index");

    // A group that was not finished must not be overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_take && valid_reg) |-> group_done)
        else $error("new request taken over an unfinished group");
`endif

endmodule

`default_nettype wire

### src/tls_core.sv
// Splitter state and the per-request decode into a group of results.
// Depends on tls_pkg.
`default_nettype none

module tls_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             take,
    input  wire logic             cmd,
    input  wire logic [7:0]       data_byte,
    output tls_pkg::bundle_t      bundle
);
    import tls_pkg::*;

    // Byte order mark check progress.
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_EF   = 2'd1;
    localparam logic [1:0] PH_EFBB = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic              cr_pending_reg, cr_pending_next;
    logic [1:0]        bom_phase_reg, bom_phase_next;
    logic              line_has_bytes_reg, line_has_bytes_next;
    logic              finalized_reg, finalized_next;
    logic [IndexW-1:0] lines_closed_reg, lines_closed_next;
    logic [IndexW-1:0] lines_inc;
    logic              closed;
    logic [CountW-1:0] n;

    // Saturating count of closed lines, as it reads after one more close.
    assign lines_inc = lines_closed_reg + {{(IndexW-1){1'b0}}, (lines_closed_reg != '1)};

    // Walk the request in order, appending results as they arise.
    always_comb begin
        cr_pending_next     = cr_pending_reg;
        bom_phase_next      = bom_phase_reg;
        line_has_bytes_next = line_has_bytes_reg;
        finalized_next      = finalized_reg;
        closed              = 1'b0;
        n                   = '0;
        bundle.slot         = '0;

        if (take) begin
            if (cmd == CMD_END) begin
                if (!finalized_reg) begin
                    // Release held mark bytes, then close any open line.
                    if (bom_phase_reg == PH_EF || bom_phase_reg == PH_EFBB) begin
                        bundle.slot[n[SlotW-1:0]] = '{kind: KIND_BYTE, value: BOM0};
                        n = n + 1'b1;
                    end
                    if (bom_phase_reg == PH_EFBB) begin
                        bundle.slot[n[SlotW-1:0]] = '{kind: KIND_BYTE, value: BOM1};
                        n = n + 1'b1;
                    end
                    bom_phase_next = PH_DONE;
                    if (cr_pending_reg || line_has_bytes_reg) begin
                        bundle.slot[n[SlotW-1:0]] = '{kind: KIND_LINE, value: 8'd0};
                        n = n + 1'b1;
                        closed              = 1'b1;
                        line_has_bytes_next = 1'b0;
                    end
                    cr_pending_next = 1'b0;
                    finalized_next  = 1'b1;
                end
                bundle.slot[n[SlotW-1:0]] = '{kind: KIND_END, value: 8'd0};
                n = n + 1'b1;
            end else if (!finalized_reg) begin
                // A pending CR closes its line before this byte counts.
                if (cr_pending_reg) begin
                    bundle.slot[n[SlotW-1:0]] = '{kind: KIND_LINE, value: 8'd0};
                    n = n + 1'b1;
                    closed              = 1'b1;
                    cr_pending_next     = 1'b0;
                    line_has_bytes_next = 1'b0;
                    bom_phase_next      = PH_DONE;
                end

                if (cr_pending_reg && data_byte == CH_LF) begin
                    // LF right after CR is part of the same line end.
                end else if (bom_phase_next == PH_WAIT && data_byte == BOM0) begin
                    bom_phase_next      = PH_EF;
                    line_has_bytes_next = 1'b1;
                end else if (bom_phase_next == PH_EF && data_byte == BOM1) begin
                    bom_phase_next = PH_EFBB;
                end else if (bom_phase_next == PH_EFBB && data_byte == BOM2) begin
                    bom_phase_next = PH_DONE;
                end else begin
                    // Not a mark: give back what was held, then handle the byte.
                    if (bom_phase_next == PH_EF || bom_phase_next == PH_EFBB) begin
                        bundle.slot[n[SlotW-1:0]] = '{kind: KIND_BYTE, value: BOM0};
                        n = n + 1'b1;
                    end
                    if (bom_phase_next == PH_EFBB) begin
                        bundle.slot[n[SlotW-1:0]] = '{kind: KIND_BYTE, value: BOM1};
                        n = n + 1'b1;
                    end
                    bom_phase_next = PH_DONE;
                    if (data_byte == CH_LF) begin
                        bundle.slot[n[SlotW-1:0]] = '{kind: KIND_LINE, value: 8'd0};
                        n = n + 1'b1;
                        closed              = 1'b1;
                        line_has_bytes_next = 1'b0;
                    end else if (data_byte == CH_CR) begin
                        cr_pending_next = 1'b1;
                    end else begin
                        bundle.slot[n[SlotW-1:0]] = '{kind: KIND_BYTE, value: data_byte};
                        n = n + 1'b1;
                        line_has_bytes_next = 1'b1;
                    end
                end
            end
        end

        bundle.count      = n;
        bundle.index      = closed ? lines_inc : '0;
        lines_closed_next = closed ? lines_inc : lines_closed_reg;
    end

    // Splitter state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cr_pending_reg     <= 1'b0;
            bom_phase_reg      <= PH_WAIT;
            line_has_bytes_reg <= 1'b0;
            finalized_reg      <= 1'b0;
            lines_closed_reg   <= '0;
        end else begin
            cr_pending_reg     <= cr_pending_next;
            bom_phase_reg      <= bom_phase_next;
            line_has_bytes_reg <= line_has_bytes_next;
            finalized_reg      <= finalized_next;
            lines_closed_reg   <= lines_closed_next;
        end
    end

endmodule

`default_nettype wire

### test/text_line_splitter_top_tb.sv
// Self-checking testbench for text_line_splitter_top: drives one byte stream with
// random idling on both handshakes and scores every result against a line-splitting predictor.
// Depends on tls_pkg and text_line_splitter_top.
`default_nettype none

module text_line_splitter_top_tb;
    import tls_pkg::*;

    // Progress of the byte order mark check on the first line.
    localparam logic [1:0] MARK_WAIT = 2'd0;
    localparam logic [1:0] MARK_ONE  = 2'd1;
    localparam logic [1:0] MARK_TWO  = 2'd2;
    localparam logic [1:0] MARK_DONE = 2'd3;

    localparam int MaxShown = 40;

    typedef logic [7:0] text_q_t[$];

    // One result as it leaves the block.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        line_end;
        logic [31:0] line_index;
        logic        stream_end;
        logic        last;
    } line_result_t;

    // Predicts the results of each accepted request and checks what comes out.
    class splitter_scoreboard;
        line_result_t pending[$];
        logic         cr_held;
        logic [1:0]   mark_phase;
        logic         line_open;
        logic         stream_done;
        logic [31:0]  lines_closed;
        int           errors;
        int           data_count;
        int           end_count;
        int           ignored_count;
        int           result_count;
        int           line_count;

        function new();
            cr_held       = 1'b0;
            mark_phase    = MARK_WAIT;
            line_open     = 1'b0;
            stream_done   = 1'b0;
            lines_closed  = '0;
            errors        = 0;
            data_count    = 0;
            end_count     = 0;
            ignored_count = 0;
            result_count  = 0;
            line_count    = 0;
        endfunction

        function void add_expect(logic [7:0] b, logic bv, logic le, logic [31:0] li,
                                 logic se);
            line_result_t r;
            r.out_byte   = b;
            r.byte_valid = bv;
            r.line_end   = le;
            r.line_index = li;
            r.stream_end = se;
            r.last       = 1'b0;
            pending = {pending, r};
        endfunction

        // Closing a line also ends the mark check for good.
        function void close_line();
            if (lines_closed != 32'hFFFF_FFFF)
                lines_closed++;
            add_expect(8'h00, 1'b0, 1'b1, lines_closed, 1'b0);
            line_open  = 1'b0;
            mark_phase = MARK_DONE;
        endfunction

        // Bytes held as a possible mark turn out to be text.
        function void release_mark();
            if (mark_phase == MARK_ONE) begin
                add_expect(BOM0, 1'b1, 1'b0, '0, 1'b0);
            end else if (mark_phase == MARK_TWO) begin
                add_expect(BOM0, 1'b1, 1'b0, '0, 1'b0);
                add_expect(BOM1, 1'b1, 1'b0, '0, 1'b0);
            end
            mark_phase = MARK_DONE;
        endfunction

        function void note_request(logic cmd, logic [7:0] b);
            int  start_n;
            logic swallow;
            start_n = pending.size();
            swallow = 1'b0;
            if (cmd == CMD_END) begin
                // End of stream: flush held mark bytes and any open line once.
                end_count++;
                if (!stream_done) begin
                    release_mark();
                    if (cr_held) begin
                        cr_held = 1'b0;
                        close_line();
                    end else if (line_open) begin
                        close_line();
                    end
                    stream_done = 1'b1;
                end
                add_expect(8'h00, 1'b0, 1'b0, '0, 1'b1);
            end else if (stream_done) begin
                ignored_count++;
            end else begin
                data_count++;
                // A CR closes its line on the next byte; an LF right after it is eaten.
                if (cr_held) begin
                    cr_held = 1'b0;
                    close_line();
                    swallow = (b == CH_LF);
                end
                if (swallow) begin
                    // Nothing more for the LF of a CR LF pair.
                end else if (mark_phase == MARK_WAIT && b == BOM0) begin
                    mark_phase = MARK_ONE;
                    line_open  = 1'b1;
                end else if (mark_phase == MARK_ONE && b == BOM1) begin
                    mark_phase = MARK_TWO;
                end else if (mark_phase == MARK_TWO && b == BOM2) begin
                    mark_phase = MARK_DONE;
                end else begin
                    release_mark();
                    if (b == CH_LF) begin
                        close_line();
                    end else if (b == CH_CR) begin
                        cr_held = 1'b1;
                    end else begin
                        add_expect(b, 1'b1, 1'b0, '0, 1'b0);
                        line_open = 1'b1;
                    end
                end
            end
            if (pending.size() > start_n)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [39:0] data, logic [2:0] flags, logic tlast);
            line_result_t got;
            line_result_t want;
            got.out_byte   = data[7:0];
            got.line_index = data[39:8];
            got.byte_valid = flags[0];
            got.line_end   = flags[1];
            got.stream_end = flags[2];
            got.last       = tlast;
            result_count++;
            if (got.line_end)
                line_count++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= MaxShown)
                    $display("%0t: unexpected result byte=%h bv=%b le=%b idx=%0d se=%b last=%b",
                             $time, got.out_byte, got.byte_valid, got.line_end,
                             got.line_index, got.stream_end, got.last);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= MaxShown)
                    $display({"%0t: mismatch expected byte=%h bv=%b le=%b idx=%0d se=%b last=%b",
                              " actual byte=%h bv=%b le=%b idx=%0d se=%b last=%b"},
                             $time, want.out_byte, want.byte_valid, want.line_end,
                             want.line_index, want.stream_end, want.last,
                             got.out_byte, got.byte_valid, got.line_end,
                             got.line_index, got.stream_end, got.last);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    logic no_idle_tx = 1'b0;
    logic no_idle_rx = 1'b0;
    logic hold_request = 1'b0;
    int   long_holds = 0;

    splitter_scoreboard splitter_sb;

    text_line_splitter_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // Free-running clock, 20 units per period.
    always #10 aclk = ~aclk;

    // Idle stretches: mostly a few cycles, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Text bytes lean toward printable ASCII but reach every value.
    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 8'($urandom_range(8'h20, 8'h7E));
        if (pick < 8)
            return 8'($urandom_range(0, 255));
        if (pick == 8) begin
            case ($urandom_range(0, 2))
                0: return BOM0;
                1: return BOM1;
                default: return BOM2;
            endcase
        end
        return 8'($urandom_range(8'h80, 8'hFF));
    endfunction

    // Offers one request and returns on the falling edge after it is taken.
    task automatic push_item(input logic cmd, input logic [7:0] b);
        int gap;
        gap = 0;
        if (!no_idle_tx && $urandom_range(0, 99) >= 70)
            gap = idle_len();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        splitter_sb.note_request(cmd, b);
        @(negedge aclk);
    endtask

    task automatic push_text(input text_q_t text);
        foreach (text[i])
            push_item(CMD_DATA, text[i]);
    endtask

    // Sender stays quiet until every outstanding result has been taken.
    task automatic wait_for_results();
        s_tvalid = 1'b0;
        while (splitter_sb.pending.size() != 0)
            @(negedge aclk);
    endtask

    // Result side: random stalls, idle-free stretches and one long hold-off.
    initial begin : result_sink
        int stall_left;
        int n;
        stall_left = 0;
        m_tready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                long_holds++;
                m_tready = 1'b0;
                for (n = 0; n < 150; n++)
                    @(negedge aclk);
                m_tready = 1'b1;
            end else if (no_idle_rx) begin
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready   = 1'b0;
                stall_left = idle_len() - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Every accepted result is scored at the rising edge.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid && m_tready)
            splitter_sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #8_000_000;
        $display("Timeout waiting for the splitter to finish.");
        $display("text_line_splitter_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        text_q_t     text;
        int          sent;
        int          len;
        int          n;
        int          pick;
        logic        hold_done;
        logic        drain_done;
        line_result_t left;

        splitter_sb = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_DATA;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // The mark can only sit at the very start, so each seed opens the stream
        // with one of the interesting first-line shapes.
        case ($urandom_range(0, 8))
            0: text = {BOM0, BOM1, BOM2, 8'h48, 8'h69, CH_LF};
            1: text = {BOM0, BOM1, BOM2, CH_LF};
            2: text = {BOM0, BOM1, BOM2, CH_CR, 8'h78};
            3: text = {BOM0, BOM1, CH_CR, CH_LF};
            4: text = {BOM0, 8'h71, CH_LF};
            5: text = {BOM0, BOM1, BOM0, CH_LF};
            6: text = {BOM0, CH_CR, CH_CR};
            7: text = {BOM0, BOM1, BOM2, BOM0, BOM1, BOM2, CH_LF};
            default: text = {8'h41, CH_LF};
        endcase
        push_text(text);

        // Byte extremes, empty lines, CR LF, double CR, lone CR and a late mark.
        text = {8'h61, 8'h00, 8'hFF, CH_LF, CH_LF, 8'h62, CH_CR, CH_LF, CH_CR, CH_CR,
                8'h63, CH_CR, 8'h64, BOM0, BOM1, BOM2, 8'h7F, 8'h80, CH_LF};
        push_text(text);
        wait_for_results();

        // Random lines of random text with mixed line endings.
        sent       = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        while (sent < 300) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 12);
            text = {};
            for (n = 0; n < len; n++)
                text = {text, text_byte()};
            pick = $urandom_range(0, 99);
            if (pick < 45)
                text = {text, CH_LF};
            else if (pick < 65)
                text = {text, CH_CR};
            else if (pick < 95)
                text = {text, CH_CR, CH_LF};
            push_text(text);
            sent += text.size();

            // Long receiver hold while the sender keeps offering back to back.
            if (sent >= 100 && !hold_done) begin
                hold_done    = 1'b1;
                no_idle_tx   = 1'b1;
                hold_request = 1'b1;
            end
            if (sent >= 150)
                no_idle_tx = 1'b0;
            if (sent >= 200 && !drain_done) begin
                drain_done = 1'b1;
                wait_for_results();
            end
            // A stretch with no idling on either side.
            no_idle_rx = (sent >= 240 && sent < 275);
            if (sent >= 240 && sent < 275)
                no_idle_tx = 1'b1;
            else if (sent >= 150)
                no_idle_tx = 1'b0;
        end
        no_idle_tx = 1'b0;
        no_idle_rx = 1'b0;

        // Leave a partial line, a pending CR or nothing open before the end.
        case ($urandom_range(0, 2))
            0: push_item(CMD_DATA, 8'h7A);
            1: push_item(CMD_DATA, CH_CR);
            default: ;
        endcase
        push_item(CMD_END, 8'h00);
        for (n = 0; n < 4; n++)
            push_item(CMD_DATA, 8'($urandom_range(0, 255)));
        push_item(CMD_END, 8'hFF);
        push_item(CMD_END, 8'h00);

        // Drain, then a short grace period for anything stray.
        s_tvalid = 1'b0;
        for (n = 0; n < 20000 && splitter_sb.pending.size() != 0; n++)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        while (splitter_sb.pending.size() != 0) begin
            left = splitter_sb.pending.pop_front();
            splitter_sb.errors++;
            if (splitter_sb.errors <= MaxShown)
                $display("%0t: missing result byte=%h bv=%b le=%b idx=%0d se=%b last=%b",
                         $time, left.out_byte, left.byte_valid, left.line_end,
                         left.line_index, left.stream_end, left.last);
        end

        $display("Sent %0d text bytes, %0d end-of-stream markers, %0d bytes after the end.",
                 splitter_sb.data_count, splitter_sb.end_count, splitter_sb.ignored_count);
        $display("Checked %0d results, %0d line ends, %0d long hold-off(s), %0d error(s).",
                 splitter_sb.result_count, splitter_sb.line_count, long_holds,
                 splitter_sb.errors);
        if (splitter_sb.errors == 0)
            $display("text_line_splitter_top regression: pass");
        else
            $display("text_line_splitter_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
